>>> src/pfcs_pkg.sv
// ----------------------------------------------------------------------------
// pfcs_pkg: shared types and constants for the prime factor counter
// Command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package pfcs_pkg;

    localparam int COUNT_BITS = 5;

    typedef struct packed {
        logic clr_start;    // begin clear sweep of marks
        logic clr_step;     // clear mark at sweep index, advance
        logic sv_start;     // begin sieve outer walk
        logic sv_step;      // one sieve sub-step
        logic q_load;       // load query
        logic q_step;       // one trial division sub-step
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic sv_done;
        logic q_done;
    } sts_t;

endpackage

>>> src/pfcs_ram.sv
// ----------------------------------------------------------------------------
// pfcs_ram: generic single-port RAM
// One read per cycle plus a write when we is high; registered read data.
// ----------------------------------------------------------------------------
module pfcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/pfcs_div.sv
// ----------------------------------------------------------------------------
// pfcs_div: restoring divider, one quotient bit per cycle
// Produces quotient and remainder of num / den.
// ----------------------------------------------------------------------------
module pfcs_div #(
    parameter int NBITS = 30,
    parameter int DBITS = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NBITS-1:0] num,
    input  logic [DBITS-1:0] den,
    output logic             done,
    output logic [NBITS-1:0] quo,
    output logic [DBITS-1:0] rem
);

    localparam int CBITS = $clog2(NBITS + 1);

    logic [NBITS-1:0] q_reg, q_next;
    logic [DBITS-1:0] r_reg, r_next;
    logic [DBITS-1:0] d_reg, d_next;
    logic [CBITS-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DBITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[NBITS-1]};
        if (go)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CBITS'(NBITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[NBITS-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = DBITS'(trial - {1'b0, d_reg});
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = DBITS'(trial);
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CBITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;

endmodule

>>> src/pfcs_datapath.sv
// ----------------------------------------------------------------------------
// pfcs_datapath: sieve and trial division datapath
// Mark RAM, prime list RAM, divider and the query registers.
// ----------------------------------------------------------------------------
module pfcs_datapath #(
    parameter int SIEVE_LIMIT = 32768,
    parameter int VALUE_BITS  = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfcs_pkg::cmd_t                cmd,
    output pfcs_pkg::sts_t                sts,
    input  logic [VALUE_BITS-1:0]         value,
    output logic [pfcs_pkg::COUNT_BITS-1:0] factor_count
);

    localparam int MDEPTH = SIEVE_LIMIT + 1;
    localparam int IBITS  = $clog2(MDEPTH + 1);
    localparam int PBITS  = $clog2(SIEVE_LIMIT + 1);
    localparam int LDEPTH = SIEVE_LIMIT;
    localparam int LBITS  = $clog2(LDEPTH);
    localparam int TBITS  = $clog2(LDEPTH + 1);
    localparam int SQBITS = 2 * PBITS;
    localparam int CMPBITS = (SQBITS > VALUE_BITS) ? SQBITS : VALUE_BITS;
    localparam int CB     = pfcs_pkg::COUNT_BITS;

    // sieve sub-phases
    localparam logic [2:0] SV_RDP   = 3'd0;
    localparam logic [2:0] SV_TSTP  = 3'd1;
    localparam logic [2:0] SV_MARK  = 3'd2;
    localparam logic [2:0] SV_RDC   = 3'd3;
    localparam logic [2:0] SV_WAITC = 3'd4;
    localparam logic [2:0] SV_COL   = 3'd5;
    localparam logic [2:0] SV_END   = 3'd6;

    // query sub-phases
    localparam logic [2:0] Q_RD    = 3'd0;
    localparam logic [2:0] Q_WAIT  = 3'd1;
    localparam logic [2:0] Q_TEST  = 3'd2;
    localparam logic [2:0] Q_DIV   = 3'd3;
    localparam logic [2:0] Q_CHK   = 3'd4;
    localparam logic [2:0] Q_SQ    = 3'd5;

    // mark RAM
    logic             m_we;
    logic [IBITS-1:0] m_addr;
    logic             m_wdata, m_rdata;
    // prime list RAM
    logic             l_we;
    logic [LBITS-1:0] l_addr;
    logic [PBITS-1:0] l_rdata;

    logic [IBITS-1:0]  idx_reg, idx_next;      // clear index / collect index
    logic [PBITS:0]    p_reg, p_next;
    logic [IBITS:0]    m_reg, m_next;
    logic [2:0]        sph_reg, sph_next;
    logic              svd_reg, svd_next;
    logic              cld_reg, cld_next;
    logic [TBITS-1:0]  tot_reg, tot_next;
    logic [2*PBITS+1:0] psq;                   // sieve prime squared

    logic [2:0]            qph_reg, qph_next;
    logic [TBITS-1:0]      qi_reg, qi_next;
    logic [PBITS-1:0]      qp_reg, qp_next;
    logic [SQBITS-1:0]     sq_reg, sq_next;
    logic [VALUE_BITS-1:0] res_reg, res_next;
    logic [CB-1:0]         cnt_reg, cnt_next;
    logic                  qd_reg, qd_next;

    logic                  dv_go, dv_done;
    logic [VALUE_BITS-1:0] dv_quo;
    logic [PBITS-1:0]      dv_rem;

    pfcs_ram #(.WIDTH(1), .DEPTH(MDEPTH + 1)) u_marks (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
    );

    pfcs_ram #(.WIDTH(PBITS), .DEPTH(LDEPTH)) u_list (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(PBITS'(idx_reg)),
        .rdata(l_rdata)
    );

    pfcs_div #(.NBITS(VALUE_BITS), .DBITS(PBITS)) u_div (
        .clk(clk), .rst_n(rst_n), .go(dv_go), .num(res_reg), .den(qp_reg),
        .done(dv_done), .quo(dv_quo), .rem(dv_rem)
    );

    assign psq = p_reg * p_reg;

    always_comb
    begin
        idx_next = idx_reg;
        p_next   = p_reg;
        m_next   = m_reg;
        sph_next = sph_reg;
        svd_next = 1'b0;
        cld_next = 1'b0;
        tot_next = tot_reg;
        qph_next = qph_reg;
        qi_next  = qi_reg;
        qp_next  = qp_reg;
        sq_next  = sq_reg;
        res_next = res_reg;
        cnt_next = cnt_reg;
        qd_next  = 1'b0;
        m_we     = 1'b0;
        m_addr   = idx_reg;
        m_wdata  = 1'b1;
        l_we     = 1'b0;
        l_addr   = LBITS'(qi_reg);
        dv_go    = 1'b0;

        if (cmd.clr_start)
        begin
            idx_next = '0;
        end
        else if (cmd.clr_step)
        begin
            m_we     = 1'b1;
            idx_next = idx_reg + 1'b1;
            if (idx_reg == IBITS'(MDEPTH - 1))
            begin
                cld_next = 1'b1;
            end
        end

        if (cmd.sv_start)
        begin
            p_next   = (PBITS + 1)'(2);
            sph_next = SV_RDP;
            tot_next = '0;
        end
        else if (cmd.sv_step)
        begin
            unique case (sph_reg)
                SV_RDP:
                begin
                    m_addr = IBITS'(p_reg);
                    if (psq > (2 * PBITS + 2)'(SIEVE_LIMIT))
                    begin
                        idx_next = IBITS'(2);
                        sph_next = SV_RDC;
                    end
                    else
                    begin
                        sph_next = SV_TSTP;
                    end
                    m_next = (IBITS + 1)'(psq);
                end
                SV_TSTP:
                begin
                    sph_next = m_rdata ? SV_MARK : SV_RDP;
                    if (!m_rdata)
                    begin
                        p_next = p_reg + 1'b1;
                    end
                end
                SV_MARK:
                begin
                    if (m_reg > (IBITS + 1)'(SIEVE_LIMIT))
                    begin
                        p_next   = p_reg + 1'b1;
                        sph_next = SV_RDP;
                    end
                    else
                    begin
                        m_addr  = IBITS'(m_reg);
                        m_we    = 1'b1;
                        m_wdata = 1'b0;
                        m_next  = m_reg + (IBITS + 1)'(p_reg);
                    end
                end
                SV_RDC:
                begin
                    if (idx_reg > IBITS'(SIEVE_LIMIT))
                    begin
                        sph_next = SV_END;
                    end
                    else
                    begin
                        m_addr   = idx_reg;
                        sph_next = SV_WAITC;
                    end
                end
                SV_WAITC:
                begin
                    sph_next = SV_COL;
                end
                SV_COL:
                begin
                    if (m_rdata)
                    begin
                        l_we     = 1'b1;
                        l_addr   = LBITS'(tot_reg);
                        tot_next = tot_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                    sph_next = SV_RDC;
                end
                SV_END:
                begin
                    svd_next = 1'b1;
                    sph_next = SV_END;
                end
                default:
                begin
                    sph_next = SV_END;
                end
            endcase
        end

        if (cmd.q_load)
        begin
            res_next = value;
            cnt_next = '0;
            qi_next  = '0;
            qph_next = Q_RD;
        end
        else if (cmd.q_step)
        begin
            unique case (qph_reg)
                Q_RD:
                begin
                    if (qi_reg == tot_reg)
                    begin
                        if (res_reg > VALUE_BITS'(1))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        qd_next = 1'b1;
                    end
                    else
                    begin
                        qph_next = Q_WAIT;
                    end
                end
                Q_WAIT:
                begin
                    qph_next = Q_SQ;
                end
                Q_SQ:
                begin
                    qp_next  = l_rdata;
                    sq_next  = SQBITS'(l_rdata) * SQBITS'(l_rdata);
                    qph_next = Q_TEST;
                end
                Q_TEST:
                begin
                    if (CMPBITS'(sq_reg) > CMPBITS'(res_reg))
                    begin
                        if (res_reg > VALUE_BITS'(1))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        qd_next = 1'b1;
                    end
                    else
                    begin
                        dv_go    = 1'b1;
                        qph_next = Q_DIV;
                    end
                end
                Q_DIV:
                begin
                    if (dv_done)
                    begin
                        qph_next = Q_CHK;
                    end
                end
                Q_CHK:
                begin
                    if (dv_rem == '0)
                    begin
                        res_next = dv_quo;
                        cnt_next = cnt_reg + 1'b1;
                        qph_next = Q_TEST;
                    end
                    else
                    begin
                        qi_next  = qi_reg + 1'b1;
                        qph_next = Q_RD;
                    end
                end
                default:
                begin
                    qph_next = Q_RD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_reg <= SV_RDP;
            qph_reg <= Q_RD;
            svd_reg <= 1'b0;
            cld_reg <= 1'b0;
            qd_reg  <= 1'b0;
            tot_reg <= '0;
            idx_reg <= '0;
            res_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sph_reg <= sph_next;
            qph_reg <= qph_next;
            svd_reg <= svd_next;
            cld_reg <= cld_next;
            qd_reg  <= qd_next;
            tot_reg <= tot_next;
            idx_reg <= idx_next;
            res_reg <= res_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        m_reg  <= m_next;
        qi_reg <= qi_next;
        qp_reg <= qp_next;
        sq_reg <= sq_next;
    end

    assign sts.clr_done  = cld_reg;
    assign sts.sv_done   = svd_reg;
    assign sts.q_done    = qd_reg;
    assign factor_count  = cnt_reg;

endmodule

>>> src/pfcs_ctrl.sv
// ----------------------------------------------------------------------------
// pfcs_ctrl: controller state machine
// Sequences clear, sieve, idle, query and zero-value phases.
// ----------------------------------------------------------------------------
module pfcs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           zero_in,
    input  pfcs_pkg::sts_t sts,
    output pfcs_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output logic           invalid
);

    localparam logic [2:0] ST_CLR0  = 3'd0;
    localparam logic [2:0] ST_CLR   = 3'd1;
    localparam logic [2:0] ST_SV    = 3'd2;
    localparam logic [2:0] ST_IDLE  = 3'd3;
    localparam logic [2:0] ST_QRY   = 3'd4;
    localparam logic [2:0] ST_ZERO  = 3'd5;

    logic [2:0] st_reg, st_next;
    logic       done_reg, done_next;
    logic       inv_reg, inv_next;

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        inv_next  = inv_reg;
        cmd       = '0;
        unique case (st_reg)
            ST_CLR0:
            begin
                cmd.clr_start = 1'b1;
                st_next       = ST_CLR;
            end
            ST_CLR:
            begin
                if (sts.clr_done)
                begin
                    cmd.sv_start = 1'b1;
                    st_next      = ST_SV;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_SV:
            begin
                if (sts.sv_done)
                begin
                    st_next = ST_IDLE;
                end
                else
                begin
                    cmd.sv_step = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.q_load = 1'b1;
                    st_next    = zero_in ? ST_ZERO : ST_QRY;
                end
            end
            ST_ZERO:
            begin
                done_next = 1'b1;
                inv_next  = 1'b1;
                st_next   = ST_IDLE;
            end
            ST_QRY:
            begin
                if (sts.q_done)
                begin
                    done_next = 1'b1;
                    inv_next  = 1'b0;
                    st_next   = ST_IDLE;
                end
                else
                begin
                    cmd.q_step = 1'b1;
                end
            end
            default:
            begin
                st_next = ST_CLR0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_CLR0;
            done_reg <= 1'b0;
            inv_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            inv_reg  <= inv_next;
        end
    end

    assign busy    = (st_reg != ST_IDLE);
    assign done    = done_reg;
    assign invalid = inv_reg;

endmodule

>>> src/prime_factor_count_sieve.sv
// ----------------------------------------------------------------------------
// prime_factor_count_sieve: prime factor count with multiplicity
// Sieve-built prime table plus trial division per query.
// ----------------------------------------------------------------------------
// Usage:
//   After reset the block clears its mark RAM, runs a sieve of Eratosthenes
//   and then collects the primes into a list RAM.
//   busy stays high through all of that.
//   A query is a transfer with start high while busy is low; value is taken
//   at that edge. busy then rises until the result is out.
//   The result (factor_count, invalid) is shown for one cycle with done high.
//   The receiver cannot stall, so there is no hold-off.
//   A zero value returns through the zero state with invalid set. Otherwise
//   each stored prime tried is read from the list, squared and tested, and
//   each division test runs the bit-serial divider until done. The divider sets
//   the pace; the walk stops once the prime squared exceeds the remainder.
//   A prime near 2^30 walks all ~3500 primes.
//   factor_count counts one more when a remainder above one is left.
// ----------------------------------------------------------------------------
module prime_factor_count_sieve #(
    parameter int SIEVE_LIMIT = 32768,
    parameter int VALUE_BITS  = 30
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [VALUE_BITS-1:0]           value,
    output logic                            done,
    output logic [pfcs_pkg::COUNT_BITS-1:0] factor_count,
    output logic                            invalid
);

    pfcs_pkg::cmd_t cmd;
    pfcs_pkg::sts_t sts;
    logic [pfcs_pkg::COUNT_BITS-1:0] cnt;

    pfcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .zero_in(value == '0),
        .sts(sts), .cmd(cmd), .busy(busy), .done(done), .invalid(invalid)
    );

    pfcs_datapath #(.SIEVE_LIMIT(SIEVE_LIMIT), .VALUE_BITS(VALUE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .value(value),
        .factor_count(cnt)
    );

    // zero query forces a zero count
    assign factor_count = invalid ? '0 : cnt;

    // no query command while the table is being built
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_load |-> !busy)
        else $error("query loaded while busy");

    // a result always ends a busy period
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // accepted start makes busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised");

endmodule

>>> dv/prime_factor_count_sieve_tb.sv
// ----------------------------------------------------------------------------
// prime_factor_count_sieve_tb: self-checking bench for the prime factor counter
// Directed rows for the edge values, then random queries. The random values
// are mostly built from small primes so that each trial-division walk stays
// short. Each result is checked against a typed-in row or a trial-division predictor.
// ----------------------------------------------------------------------------
module prime_factor_count_sieve_tb;

    localparam int SIEVE_LIMIT  = 32768;
    localparam int VALUE_BITS   = 30;
    localparam int COUNT_BITS   = pfcs_pkg::COUNT_BITS;
    localparam int RANDOM_ITEMS = 140;
    localparam int DIRECTED_ROWS = 17;
    // Longest stretch with no transfer: the power-up sieve, or a prime query
    // near 2^30 (a walk over about 3500 primes), several times over.
    localparam int STALL_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        logic [COUNT_BITS-1:0] count;
        logic                  inval;
    } factor_result_t;

    typedef struct {
        logic [VALUE_BITS-1:0] val;
        bit                    fixed;   // expected result typed in below
        logic [COUNT_BITS-1:0] count;
        logic                  inval;
    } query_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] value;
    logic                  done;
    logic [COUNT_BITS-1:0] factor_count;
    logic                  invalid;

    factor_result_t pending_counts[$];
    int             prime_table[$];
    bit             failed;
    int             idle_cycles;

    prime_factor_count_sieve #(
        .SIEVE_LIMIT(SIEVE_LIMIT),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .done        (done),
        .factor_count(factor_count),
        .invalid     (invalid)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Build the predictor's own prime table with a plain sieve.
    task automatic build_prime_table();
        bit composite[];
        composite = new[SIEVE_LIMIT + 1];
        for (int p = 2; p * p <= SIEVE_LIMIT; p++)
        begin
            if (!composite[p])
            begin
                for (int m = p * p; m <= SIEVE_LIMIT; m += p)
                    composite[m] = 1'b1;
            end
        end
        for (int p = 2; p <= SIEVE_LIMIT; p++)
        begin
            if (!composite[p])
                prime_table.insert(prime_table.size(), p);
        end
    endtask

    // Big omega by trial division; the walk ends once p*p passes the remainder.
    function automatic factor_result_t count_prime_factors(logic [VALUE_BITS-1:0] v);
        factor_result_t res;
        longint         rem;
        int             cnt;
        rem = v;
        cnt = 0;
        if (v == 0)
        begin
            res.count = '0;
            res.inval = 1'b1;
            return res;
        end
        foreach (prime_table[i])
        begin
            longint p;
            p = prime_table[i];
            if (p * p > rem)
                break;
            while (rem % p == 0)
            begin
                rem = rem / p;
                cnt++;
            end
        end
        if (rem > 1)
            cnt++;
        res.count = cnt[COUNT_BITS-1:0];
        res.inval = 1'b0;
        return res;
    endfunction

    // Random query: mostly small primes times a modest cofactor, so the walk
    // stays short; a few full-width values take the long path.
    function automatic logic [VALUE_BITS-1:0] random_query();
        int     mode;
        longint prod;
        int     reps;
        mode = $urandom_range(0, 99);
        if (mode < 2)
            return '0;
        if (mode < 5)
            return VALUE_BITS'($urandom);
        if (mode < 10)
            return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
        prod = (mode < 25) ? $urandom_range(1, 1 << 20) : $urandom_range(1, 1 << 14);
        reps = $urandom_range(0, 12);
        for (int k = 0; k < reps; k++)
        begin
            longint p;
            p = prime_table[$urandom_range(0, 9)];
            if (prod * p < (longint'(1) << VALUE_BITS))
                prod = prod * p;
        end
        return VALUE_BITS'(prod);
    endfunction

    // One query transfer, with an optional gap before it. start stays high
    // across back-to-back transfers.
    task automatic send_query(logic [VALUE_BITS-1:0] v, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do @(posedge clk); while (busy);
    endtask

    // Result checker: every done pulse is matched against the oldest pending entry.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: unexpected result count=%0d invalid=%0b",
                         $time, factor_count, invalid);
                failed = 1'b1;
            end
            else
            begin
                factor_result_t exp_res;
                exp_res = pending_counts.pop_front();
                if (factor_count !== exp_res.count)
                begin
                    $display("%0t: factor_count expected %0d actual %0d",
                             $time, exp_res.count, factor_count);
                    failed = 1'b1;
                end
                if (invalid !== exp_res.inval)
                begin
                    $display("%0t: invalid expected %0b actual %0b",
                             $time, exp_res.inval, invalid);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((start && !busy && rst_n) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        query_row_t     rows[DIRECTED_ROWS];
        factor_result_t exp_res;
        int             burst;
        logic [VALUE_BITS-1:0] v;

        failed      = 1'b0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        build_prime_table();

        // Directed rows: fixed expectations only where obvious.
        rows = '{
            '{30'd0,          1'b1, 5'd0,  1'b1}, // zero is flagged
            '{30'd1,          1'b1, 5'd0,  1'b0}, // one has no factors
            '{30'd2,          1'b1, 5'd1,  1'b0},
            '{30'h2000_0000,  1'b1, 5'd29, 1'b0}, // 2^29, top count
            '{30'h3FFF_FFFF,  1'b1, 5'd7,  1'b0}, // 3*3*7*11*31*151*331
            '{30'd387420489,  1'b1, 5'd18, 1'b0}, // 3^18
            '{30'd0,          1'b1, 5'd0,  1'b1}, // zero right after data
            '{30'd3,          1'b0, 5'd0,  1'b0},
            '{30'd4,          1'b0, 5'd0,  1'b0},
            '{30'd510510,     1'b0, 5'd0,  1'b0},
            '{30'd32767,      1'b0, 5'd0,  1'b0},
            '{30'd32768,      1'b0, 5'd0,  1'b0},
            '{30'd32749,      1'b0, 5'd0,  1'b0}, // largest table prime
            '{30'd65498,      1'b0, 5'd0,  1'b0}, // 2*32749, leftover prime
            '{30'h1555_5555,  1'b0, 5'd0,  1'b0},
            '{30'd1073741789, 1'b0, 5'd0,  1'b0}, // prime near 2^30: full walk
            '{30'd1072497001, 1'b0, 5'd0,  1'b0}  // 32749 squared
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part; the first transfer also waits out the power-up sieve.
        foreach (rows[i])
        begin
            send_query(rows[i].val, (i % 3 == 0) ? $urandom_range(0, 4) : 0);
            exp_res = count_prime_factors(rows[i].val);
            if (rows[i].fixed)
            begin
                exp_res.count = rows[i].count;
                exp_res.inval = rows[i].inval;
            end
            pending_counts.insert(pending_counts.size(), exp_res);
        end

        // Random part, sent in bursts with random gaps.
        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Halfway: hold off until every pending result has come back.
            if (n == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                do @(posedge clk); while (pending_counts.size() != 0);
            end
            v = random_query();
            if (burst == 0)
            begin
                burst = $urandom_range(1, 8);
                send_query(v, $urandom_range(1, 20));
            end
            else
                send_query(v, 0);
            burst--;
            pending_counts.insert(pending_counts.size(), count_prime_factors(v));
        end
        start <= 1'b0;

        do @(posedge clk); while (pending_counts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
